@@ hw/rtl/resp_array_bulk_parser_unit_assert.svh @@
// assertion macros shared by the parser modules
// each expects clk and rst_n in scope
`ifndef RESP_ARRAY_BULK_PARSER_UNIT_ASSERT_SVH
`define RESP_ARRAY_BULK_PARSER_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define RAB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define RAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rab_pkg.sv @@
`timescale 1ns / 1ps
package rab_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_STAR,
    CLS_DOLLAR,
    CLS_CR,
    CLS_LF,
    CLS_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    PH_WAIT,
    PH_COUNT,
    PH_COUNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_PAYLOAD,
    PH_PAY_CR,
    PH_PAY_LF
  } phase_t;

  typedef enum logic [1:0] {
    EV_DATA,
    EV_TOKEN,
    EV_EMPTY,
    EV_ERROR
  } ev_t;

  typedef struct packed {
    logic [7:0] byte_val;
    cls_t       cls;
  } tok_t;

  typedef struct packed {
    ev_t         event_res;
    logic [7:0]  data_byte;
    logic [15:0] token_index;
    logic [31:0] token_length;
    logic        frame_done;
  } res_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

@@ hw/rtl/rab_if.sv @@
`timescale 1ns / 1ps
interface rab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface rab_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [15:0] token_index;
  logic [31:0] token_length;
  logic        frame_done;

  modport source (output valid, output event_res, output data_byte, output token_index,
                  output token_length, output frame_done, input ready);
  modport sink (input valid, input event_res, input data_byte, input token_index,
                input token_length, input frame_done, output ready);
endinterface

@@ hw/rtl/rab_front.sv @@
`timescale 1ns / 1ps
`include "resp_array_bulk_parser_unit_assert.svh"
module rab_front (
  input  logic          clk,
  input  logic          rst_n,
  rab_in_if.sink        in_ch,
  output rab_pkg::hs_t  tok_hs_o,
  input  logic          tok_ready_i,
  output rab_pkg::tok_t tok_o
);
  import rab_pkg::*;

  tok_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  tok_t              tok_in;
  logic              push, pop;

  // byte classification
  always_comb begin
    tok_in.byte_val = in_ch.byte_in;
    if (in_ch.byte_in >= CH_ZERO && in_ch.byte_in <= CH_NINE) begin
      tok_in.cls = CLS_DIGIT;
    end else if (in_ch.byte_in == CH_STAR) begin
      tok_in.cls = CLS_STAR;
    end else if (in_ch.byte_in == CH_DOLLAR) begin
      tok_in.cls = CLS_DOLLAR;
    end else if (in_ch.byte_in == CH_CR) begin
      tok_in.cls = CLS_CR;
    end else if (in_ch.byte_in == CH_LF) begin
      tok_in.cls = CLS_LF;
    end else begin
      tok_in.cls = CLS_OTHER;
    end
  end

  assign in_ch.ready    = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push           = in_ch.valid && in_ch.ready;
  assign tok_hs_o.valid = (cnt_r != '0);
  assign tok_hs_o.ready = tok_ready_i;
  assign pop            = tok_hs_o.valid && tok_ready_i;
  assign tok_o          = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= tok_in;
    end
  end

  `RAB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
  `RAB_ASSERT_NEXT(a_cnt_track, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "push lost")
  `RAB_ASSERT_NOW(a_digit_head, tok_hs_o.valid && tok_o.cls == CLS_DIGIT,
                  tok_o.byte_val >= CH_ZERO && tok_o.byte_val <= CH_NINE, "bad digit class")

endmodule

@@ hw/rtl/rab_core.sv @@
`timescale 1ns / 1ps
`include "resp_array_bulk_parser_unit_assert.svh"
module rab_core #(
  parameter int unsigned ARG_COUNT_BITS = 16,
  parameter int unsigned LENGTH_BITS    = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rab_pkg::hs_t  tok_hs_i,
  output logic          tok_ready_o,
  input  rab_pkg::tok_t tok_i,
  rab_out_if.source     out_ch
);
  import rab_pkg::*;

  localparam int unsigned CW = ARG_COUNT_BITS;
  localparam int unsigned LW = LENGTH_BITS;

  phase_t          phase_r, phase_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   left_r, left_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r, res;

  logic            out_free, advance, emit, bad, is_digit;
  logic [3:0]      dval;
  logic [CW+3:0]   total_ext, total_acc;
  logic [LW+3:0]   len_ext, len_acc;
  logic            total_ovf, len_ovf;
  logic [CW:0]     pos_inc;
  logic            last_tok;
  logic [CW+15:0]  pos_wide;
  logic [LW+31:0]  len_wide;
  logic [LW-1:0]   left_dec;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign tok_ready_o = out_free;
  assign advance     = tok_hs_i.valid && out_free;

  assign is_digit  = (tok_i.cls == CLS_DIGIT);
  assign dval      = tok_i.byte_val[3:0];
  // times ten plus digit, overflow shows in the top four bits
  assign total_ext = {4'b0, total_r};
  assign total_acc = (total_ext << 3) + (total_ext << 1) + (CW + 4)'(dval);
  assign total_ovf = |total_acc[CW+3:CW];
  assign len_ext   = {4'b0, len_r};
  assign len_acc   = (len_ext << 3) + (len_ext << 1) + (LW + 4)'(dval);
  assign len_ovf   = |len_acc[LW+3:LW];

  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  assign last_tok = (pos_inc >= {1'b0, total_r});
  assign pos_wide = {16'b0, pos_r};
  assign len_wide = {32'b0, len_r};
  assign left_dec = (left_r != '0) ? left_r - 1'b1 : left_r;

  // malformed byte or overflow in the current phase
  always_comb begin
    unique case (phase_r)
      PH_WAIT:     bad = 1'b0;
      PH_COUNT:    bad = is_digit ? total_ovf : (tok_i.cls != CLS_CR);
      PH_COUNT_LF: bad = (tok_i.cls != CLS_LF);
      PH_DOLLAR:   bad = (tok_i.cls != CLS_DOLLAR);
      PH_LEN:      bad = is_digit ? len_ovf : (tok_i.cls != CLS_CR);
      PH_LEN_LF:   bad = (tok_i.cls != CLS_LF);
      PH_PAYLOAD:  bad = 1'b0;
      PH_PAY_CR:   bad = (tok_i.cls != CLS_CR);
      PH_PAY_LF:   bad = (tok_i.cls != CLS_LF);
      default:     bad = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    total_nxt = total_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    if (advance) begin
      if (bad) begin
        phase_nxt = PH_WAIT;
        total_nxt = '0;
        pos_nxt   = '0;
        len_nxt   = '0;
        left_nxt  = '0;
      end else begin
        unique case (phase_r)
          PH_WAIT: begin
            if (tok_i.cls == CLS_STAR) begin
              phase_nxt = PH_COUNT;
              total_nxt = '0;
              pos_nxt   = '0;
              len_nxt   = '0;
              left_nxt  = '0;
            end
          end
          PH_COUNT: begin
            if (is_digit) begin
              total_nxt = total_acc[CW-1:0];
            end else begin
              phase_nxt = PH_COUNT_LF;
            end
          end
          PH_COUNT_LF: begin
            if (total_r == '0) begin
              phase_nxt = PH_WAIT;
              total_nxt = '0;
              pos_nxt   = '0;
              len_nxt   = '0;
              left_nxt  = '0;
            end else begin
              pos_nxt   = '0;
              phase_nxt = PH_DOLLAR;
            end
          end
          PH_DOLLAR: begin
            len_nxt   = '0;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            if (is_digit) begin
              len_nxt = len_acc[LW-1:0];
            end else begin
              phase_nxt = PH_LEN_LF;
            end
          end
          PH_LEN_LF: begin
            left_nxt  = len_r;
            phase_nxt = (len_r == '0) ? PH_PAY_CR : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            left_nxt = left_dec;
            if (left_dec == '0) begin
              phase_nxt = PH_PAY_CR;
            end
          end
          PH_PAY_CR: begin
            phase_nxt = PH_PAY_LF;
          end
          PH_PAY_LF: begin
            if (last_tok) begin
              phase_nxt = PH_WAIT;
              total_nxt = '0;
              pos_nxt   = '0;
              len_nxt   = '0;
              left_nxt  = '0;
            end else begin
              pos_nxt   = pos_inc[CW-1:0];
              len_nxt   = '0;
              phase_nxt = PH_DOLLAR;
            end
          end
          default: begin
            phase_nxt = PH_WAIT;
            total_nxt = '0;
            pos_nxt   = '0;
            len_nxt   = '0;
            left_nxt  = '0;
          end
        endcase
      end
    end
  end

  // result for the current item
  always_comb begin
    emit             = 1'b0;
    res.event_res    = EV_ERROR;
    res.data_byte    = '0;
    res.token_index  = pos_wide[15:0];
    res.token_length = len_wide[31:0];
    res.frame_done   = 1'b0;
    if (bad) begin
      emit = 1'b1;
    end else begin
      unique case (phase_r)
        PH_COUNT_LF: begin
          if (total_r == '0) begin
            emit             = 1'b1;
            res.event_res    = EV_EMPTY;
            res.token_index  = '0;
            res.token_length = '0;
            res.frame_done   = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          emit          = 1'b1;
          res.event_res = EV_DATA;
          res.data_byte = tok_i.byte_val;
        end
        PH_PAY_LF: begin
          emit           = 1'b1;
          res.event_res  = EV_TOKEN;
          res.frame_done = last_tok;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      total_r     <= '0;
      pos_r       <= '0;
      len_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_res    = res_r.event_res;
  assign out_ch.data_byte    = res_r.data_byte;
  assign out_ch.token_index  = res_r.token_index;
  assign out_ch.token_length = res_r.token_length;
  assign out_ch.frame_done   = res_r.frame_done;

  `RAB_ASSERT_NOW(a_done_kind, out_valid_r && res_r.frame_done,
                  res_r.event_res == EV_TOKEN || res_r.event_res == EV_EMPTY,
                  "frame close on wrong event")
  `RAB_ASSERT_NEXT(a_err_resync, advance && bad, phase_r == PH_WAIT && total_r == '0,
                   "no resync after error")
  `RAB_ASSERT_NOW(a_pos_range,
                  phase_r == PH_DOLLAR || phase_r == PH_LEN || phase_r == PH_LEN_LF ||
                  phase_r == PH_PAYLOAD || phase_r == PH_PAY_CR || phase_r == PH_PAY_LF,
                  pos_r < total_r, "token index past count")
  `RAB_ASSERT_NOW(a_payload_left, phase_r == PH_PAYLOAD, left_r != '0,
                  "payload phase with nothing left")

endmodule

@@ hw/rtl/resp_array_bulk_parser_unit.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// in_ch     in   valid/ready        byte_in
// out_ch    out  valid/ready        event_res, data_byte, token_index,
//                                   token_length, frame_done
// one byte per cycle sustained while out_ch does not stall; a result passes through the
// classify queue (two entries) and the registered result stage
// rst_n is synchronous; parser returns to waiting for a frame start
// an output stall backs up into the queue, then drops in_ch.ready
module resp_array_bulk_parser_unit #(
  parameter int unsigned ARG_COUNT_BITS = 16,
  parameter int unsigned LENGTH_BITS    = 32
) (
  input logic       clk,
  input logic       rst_n,
  rab_in_if.sink    in_ch,
  rab_out_if.source out_ch
);
  import rab_pkg::*;

  hs_t  tok_hs;
  logic tok_ready;
  tok_t tok;

  rab_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .tok_hs_o    (tok_hs),
    .tok_ready_i (tok_ready),
    .tok_o       (tok)
  );

  rab_core #(
    .ARG_COUNT_BITS (ARG_COUNT_BITS),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_hs_i    (tok_hs),
    .tok_ready_o (tok_ready),
    .tok_i       (tok),
    .out_ch      (out_ch)
  );

endmodule
